>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/cget_pkg.sv
// Package for the compatibility graph edge test: request/result types,
// command codes, table sizes and small helper functions. No dependencies.
`timescale 1ns / 1ps

package cget_pkg;

  localparam int MAX_ATOMS = 64;
  localparam int ATOM_W    = $clog2(MAX_ATOMS);
  localparam int IDX_W     = 6;
  localparam int ELEM_W    = 7;
  localparam int CMD_W     = 3;

  localparam logic [ELEM_W-1:0] HYDROGEN = ELEM_W'(1);

  localparam logic [CMD_W-1:0] CMD_SET_L  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_R  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BOND_L = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BOND_R = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  first_atom_left;
    logic [IDX_W-1:0]  first_atom_right;
    logic [IDX_W-1:0]  second_atom_left;
    logic [IDX_W-1:0]  second_atom_right;
    logic [ELEM_W-1:0] element_number;
  } req_t;

  typedef struct packed {
    logic first_node_valid;
    logic second_node_valid;
    logic edge_present;
    logic bond_left;
    logic bond_right;
  } rsp_t;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return (32'(idx) < MAX_ATOMS);
  endfunction

  function automatic logic [ATOM_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
    return ATOM_W'(idx);
  endfunction

  // A node needs matching, nonzero, non-hydrogen elements.
  function automatic logic node_ok(input logic [ELEM_W-1:0] el,
                                   input logic [ELEM_W-1:0] er);
    return (el != '0) && (el == er) && (el != HYDROGEN);
  endfunction

endpackage

>>> rtl/cget_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module cget_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/compatibility_graph_edge_test.sv
// Top level of the compatibility graph edge test: element and bond tables
// of two molecules in RAM, command sequencer, result register.
// Depends on cget_pkg, cget_ram and assert_macros.svh.
//
//   channel | direction | payload | handshake
//   in_     | input     | req_t   | in_valid / in_ready
//   out_    | output    | rsp_t   | out_valid / out_ready
//
// Query, atom load, clear and unused commands go from idle to the finish step;
// a bond passes through BOND_A and BOND_B first (a self or out-of-range bond
// skips BOND_B), for the read-modify-write of two rows through one read port.
// Reset clears the per-entry valid bits at once; no clearing pass is needed.
// A clear-bonds request drops all row valid bits together when it is accepted.
// A request is taken whenever the sequencer is idle, even while a result
// waits; it then holds in its last step until the result register frees up.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module compatibility_graph_edge_test (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cget_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cget_pkg::rsp_t out_data
);

  import cget_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_BOND_A = 2'd1;
  localparam logic [1:0] ST_BOND_B = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_r, state_nxt;
  req_t       req_r;
  req_t       cur;
  logic       in_accept;

  logic       out_valid_r, out_valid_nxt;
  rsp_t       out_data_r;
  rsp_t       rsp;
  logic       out_load;

  logic [MAX_ATOMS-1:0] elem_vld_l_r, elem_vld_r_r;
  logic [MAX_ATOMS-1:0] bond_vld_l_r, bond_vld_r_r;

  // element RAMs, duplicated so both nodes read in the same cycle
  logic              elem_we_l, elem_we_r;
  logic [ELEM_W-1:0] el_l0, el_l1, el_r0, el_r1;

  // bond row RAMs
  logic                 side_right;
  logic [IDX_W-1:0]     bond_a, bond_b;
  logic                 bond_ok;
  logic                 bond_wr;
  logic [ATOM_W-1:0]    bond_waddr;
  logic [ATOM_W-1:0]    bond_wbit;
  logic [MAX_ATOMS-1:0] bond_base;
  logic [MAX_ATOMS-1:0] bond_wdata;
  logic                 bond_we_l, bond_we_r;
  logic [ATOM_W-1:0]    bond_raddr_l, bond_raddr_r;
  logic [MAX_ATOMS-1:0] row_l, row_r;

  // query terms
  logic [ELEM_W-1:0] e_fl, e_fr, e_sl, e_sr;
  logic              v1, v2, bl, br;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cur       = (state_r == ST_IDLE) ? in_data : req_r;

  // ---------------- element tables ----------------
  assign elem_we_l = in_accept && (in_data.command == CMD_SET_L)
                     && in_range(in_data.first_atom_left);
  assign elem_we_r = in_accept && (in_data.command == CMD_SET_R)
                     && in_range(in_data.first_atom_right);

  cget_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ATOMS)) u_elem_l0 (
    .clk(clk), .we(elem_we_l), .waddr(to_addr(in_data.first_atom_left)),
    .wdata(in_data.element_number), .raddr(to_addr(cur.first_atom_left)),
    .rdata(el_l0)
  );
  cget_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ATOMS)) u_elem_l1 (
    .clk(clk), .we(elem_we_l), .waddr(to_addr(in_data.first_atom_left)),
    .wdata(in_data.element_number), .raddr(to_addr(cur.second_atom_left)),
    .rdata(el_l1)
  );
  cget_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ATOMS)) u_elem_r0 (
    .clk(clk), .we(elem_we_r), .waddr(to_addr(in_data.first_atom_right)),
    .wdata(in_data.element_number), .raddr(to_addr(cur.first_atom_right)),
    .rdata(el_r0)
  );
  cget_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ATOMS)) u_elem_r1 (
    .clk(clk), .we(elem_we_r), .waddr(to_addr(in_data.first_atom_right)),
    .wdata(in_data.element_number), .raddr(to_addr(cur.second_atom_right)),
    .rdata(el_r1)
  );

  // ---------------- bond tables ----------------
  assign side_right = (req_r.command == CMD_BOND_R);
  assign bond_a     = side_right ? req_r.first_atom_right  : req_r.first_atom_left;
  assign bond_b     = side_right ? req_r.second_atom_right : req_r.second_atom_left;
  assign bond_ok    = in_range(bond_a) && in_range(bond_b);
  assign bond_wr    = bond_ok && ((state_r == ST_BOND_A) || (state_r == ST_BOND_B));

  // first step writes row a with bit b, second step row b with bit a
  assign bond_waddr = (state_r == ST_BOND_A) ? to_addr(bond_a) : to_addr(bond_b);
  assign bond_wbit  = (state_r == ST_BOND_A) ? to_addr(bond_b) : to_addr(bond_a);

  always_comb begin
    bond_base = '0;
    if (side_right) begin
      if (bond_vld_r_r[bond_waddr]) begin
        bond_base = row_r;
      end
    end else begin
      if (bond_vld_l_r[bond_waddr]) begin
        bond_base = row_l;
      end
    end
    bond_wdata = bond_base | (MAX_ATOMS'(1) << bond_wbit);
  end

  assign bond_we_l = bond_wr && !side_right;
  assign bond_we_r = bond_wr && side_right;

  // during the first bond step fetch row b; otherwise hold the first atom's row
  assign bond_raddr_l = (state_r == ST_BOND_A) ? to_addr(cur.second_atom_left)
                                               : to_addr(cur.first_atom_left);
  assign bond_raddr_r = (state_r == ST_BOND_A) ? to_addr(cur.second_atom_right)
                                               : to_addr(cur.first_atom_right);

  cget_ram #(.WIDTH(MAX_ATOMS), .DEPTH(MAX_ATOMS)) u_bond_l (
    .clk(clk), .we(bond_we_l), .waddr(bond_waddr), .wdata(bond_wdata),
    .raddr(bond_raddr_l), .rdata(row_l)
  );
  cget_ram #(.WIDTH(MAX_ATOMS), .DEPTH(MAX_ATOMS)) u_bond_r (
    .clk(clk), .we(bond_we_r), .waddr(bond_waddr), .wdata(bond_wdata),
    .raddr(bond_raddr_r), .rdata(row_r)
  );

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_vld_l_r <= '0;
      elem_vld_r_r <= '0;
      bond_vld_l_r <= '0;
      bond_vld_r_r <= '0;
    end else begin
      if (elem_we_l) begin
        elem_vld_l_r[to_addr(in_data.first_atom_left)] <= 1'b1;
      end
      if (elem_we_r) begin
        elem_vld_r_r[to_addr(in_data.first_atom_right)] <= 1'b1;
      end
      if (in_accept && (in_data.command == CMD_CLEAR)) begin
        bond_vld_l_r <= '0;
        bond_vld_r_r <= '0;
      end else begin
        if (bond_we_l) begin
          bond_vld_l_r[bond_waddr] <= 1'b1;
        end
        if (bond_we_r) begin
          bond_vld_r_r[bond_waddr] <= 1'b1;
        end
      end
    end
  end

  // ---------------- query evaluation ----------------
  always_comb begin
    e_fl = (in_range(req_r.first_atom_left)
            && elem_vld_l_r[to_addr(req_r.first_atom_left)]) ? el_l0 : '0;
    e_sl = (in_range(req_r.second_atom_left)
            && elem_vld_l_r[to_addr(req_r.second_atom_left)]) ? el_l1 : '0;
    e_fr = (in_range(req_r.first_atom_right)
            && elem_vld_r_r[to_addr(req_r.first_atom_right)]) ? el_r0 : '0;
    e_sr = (in_range(req_r.second_atom_right)
            && elem_vld_r_r[to_addr(req_r.second_atom_right)]) ? el_r1 : '0;
    v1 = node_ok(e_fl, e_fr);
    v2 = node_ok(e_sl, e_sr);
    bl = in_range(req_r.first_atom_left) && in_range(req_r.second_atom_left)
         && bond_vld_l_r[to_addr(req_r.first_atom_left)]
         && row_l[to_addr(req_r.second_atom_left)];
    br = in_range(req_r.first_atom_right) && in_range(req_r.second_atom_right)
         && bond_vld_r_r[to_addr(req_r.first_atom_right)]
         && row_r[to_addr(req_r.second_atom_right)];

    rsp = '0;
    if (req_r.command == CMD_QUERY) begin
      rsp.first_node_valid  = v1;
      rsp.second_node_valid = v2;
      rsp.bond_left         = bl;
      rsp.bond_right        = br;
      rsp.edge_present      = v1 && v2
                              && (req_r.first_atom_left != req_r.second_atom_left)
                              && (req_r.first_atom_right != req_r.second_atom_right)
                              && (bl == br);
    end
  end

  // ---------------- sequencer ----------------
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if ((in_data.command == CMD_BOND_L) || (in_data.command == CMD_BOND_R)) begin
            state_nxt = ST_BOND_A;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_BOND_A: begin
        // a self bond sets its one bit in the first step
        if (!bond_ok || (bond_a == bond_b)) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_BOND_B;
        end
      end
      ST_BOND_B: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks ----------------
  `ASSERT_IMPLIES(a_edge_needs_nodes, clk, rst_n, out_valid && out_data.edge_present, out_data.first_node_valid && out_data.second_node_valid)
  `ASSERT_NEXT(a_clear_drops_rows, clk, rst_n, in_accept && (in_data.command == CMD_CLEAR), (bond_vld_l_r == '0) && (bond_vld_r_r == '0))
  `ASSERT_IMPLIES(a_bond_write_busy, clk, rst_n, bond_we_l || bond_we_r, !in_ready && (req_r.command == CMD_BOND_L || req_r.command == CMD_BOND_R))

endmodule

>>> tb/sv/compatibility_graph_edge_test_test.sv
// Testbench for compatibility_graph_edge_test: directed and random requests
// against a scoreboard that keeps its own copy of the element and bond tables.
// Depends on cget_pkg and the compatibility_graph_edge_test RTL.
`timescale 1ns / 1ps

module compatibility_graph_edge_test_test;
  import cget_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int RANDOM_REQUESTS = 750;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ATOM_POOL       = 8;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_WAVE} stall_e;

  // Element and bond tables of both molecules, plus the answers still owed.
  class compat_tracker;
    bit [ELEM_W-1:0]    elem_l [MAX_ATOMS];
    bit [ELEM_W-1:0]    elem_r [MAX_ATOMS];
    bit [MAX_ATOMS-1:0] bond_l [MAX_ATOMS];
    bit [MAX_ATOMS-1:0] bond_r [MAX_ATOMS];
    rsp_t answers [$];
    int mismatches;

    function bit pairs(bit [ELEM_W-1:0] el, bit [ELEM_W-1:0] er);
      return el != '0 && el == er && el != HYDROGEN;
    endfunction

    // Find a molecule-two atom in the pool whose element matches the given atom.
    function logic [IDX_W-1:0] partner(logic [IDX_W-1:0] left);
      int start;
      start = $urandom_range(0, ATOM_POOL - 1);
      for (int k = 0; k < ATOM_POOL; k++) begin
        if (elem_r[(start + k) % ATOM_POOL] == elem_l[left])
          return IDX_W'((start + k) % ATOM_POOL);
      end
      return IDX_W'(start);
    endfunction

    function void take_request(req_t q);
      rsp_t a;
      a = '0;
      case (q.command)
        CMD_SET_L: elem_l[q.first_atom_left] = q.element_number;
        CMD_SET_R: elem_r[q.first_atom_right] = q.element_number;
        CMD_BOND_L: begin
          bond_l[q.first_atom_left][q.second_atom_left] = 1'b1;
          bond_l[q.second_atom_left][q.first_atom_left] = 1'b1;
        end
        CMD_BOND_R: begin
          bond_r[q.first_atom_right][q.second_atom_right] = 1'b1;
          bond_r[q.second_atom_right][q.first_atom_right] = 1'b1;
        end
        CMD_QUERY: begin
          a.first_node_valid  = pairs(elem_l[q.first_atom_left], elem_r[q.first_atom_right]);
          a.second_node_valid = pairs(elem_l[q.second_atom_left], elem_r[q.second_atom_right]);
          a.bond_left  = bond_l[q.first_atom_left][q.second_atom_left];
          a.bond_right = bond_r[q.first_atom_right][q.second_atom_right];
          a.edge_present = a.first_node_valid && a.second_node_valid
                           && q.first_atom_left != q.second_atom_left
                           && q.first_atom_right != q.second_atom_right
                           && a.bond_left == a.bond_right;
        end
        CMD_CLEAR: begin
          for (int i = 0; i < MAX_ATOMS; i++) begin
            bond_l[i] = '0;
            bond_r[i] = '0;
          end
        end
        default: ;
      endcase
      answers.insert(answers.size(), a);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %b with no request pending", got);
        return;
      end
      want = answers.pop_front();
      if (got.first_node_valid !== want.first_node_valid
          || got.second_node_valid !== want.second_node_valid
          || got.edge_present !== want.edge_present
          || got.bond_left !== want.bond_left
          || got.bond_right !== want.bond_right) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch (v1 v2 edge bl br): expected %b %b %b %b %b, got %b %b %b %b %b",
                   want.first_node_valid, want.second_node_valid, want.edge_present,
                   want.bond_left, want.bond_right,
                   got.first_node_valid, got.second_node_valid, got.edge_present,
                   got.bond_left, got.bond_right);
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  req_t   in_data = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  rsp_t   out_data;

  compat_tracker sb = new();
  int     cycle_count = 0;
  int     burst_left = 1;
  stall_e stall_mode = RDY_ALWAYS;
  int     phase_left = 0;

  compatibility_graph_edge_test dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.take_request(in_data);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data);
  end

  // Receiver: switch among four stall patterns, each held for a random phase.
  always @(posedge clk) begin
    if (phase_left == 0) begin
      stall_mode <= stall_e'($urandom_range(0, 3));
      phase_left <= $urandom_range(8, 80);
    end else begin
      phase_left <= phase_left - 1;
    end
    case (stall_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
      default:    out_ready <= (phase_left % 8) < 4;
    endcase
  end

  function automatic req_t mk(logic [CMD_W-1:0] cmd, int fl, int fr, int sl, int sr, int el);
    req_t q;
    q.command           = cmd;
    q.first_atom_left   = IDX_W'(fl);
    q.first_atom_right  = IDX_W'(fr);
    q.second_atom_left  = IDX_W'(sl);
    q.second_atom_right = IDX_W'(sr);
    q.element_number    = ELEM_W'(el);
    return q;
  endfunction

  // Mostly a small pool of atoms so bonds and queries meet often.
  function automatic logic [IDX_W-1:0] pick_atom();
    if ($urandom_range(0, 4) == 0)
      return IDX_W'($urandom_range(0, MAX_ATOMS - 1));
    return IDX_W'($urandom_range(0, ATOM_POOL - 1));
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       return '0;
      1:       return HYDROGEN;
      2, 3:    return ELEM_W'(6);
      4, 5:    return ELEM_W'(8);
      6:       return ELEM_W'(7);
      default: return ELEM_W'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic req_t random_request();
    req_t q;
    int   roll;
    roll = $urandom_range(0, 99);
    q.first_atom_left   = pick_atom();
    q.first_atom_right  = pick_atom();
    q.second_atom_left  = pick_atom();
    q.second_atom_right = pick_atom();
    q.element_number    = pick_element();
    if (roll < 14)      q.command = CMD_SET_L;
    else if (roll < 28) q.command = CMD_SET_R;
    else if (roll < 40) q.command = CMD_BOND_L;
    else if (roll < 52) q.command = CMD_BOND_R;
    else if (roll < 54) q.command = CMD_CLEAR;
    else if (roll < 57) begin
      q.command           = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      q.first_atom_left   = IDX_W'($urandom_range(0, 63));
      q.second_atom_right = IDX_W'($urandom_range(0, 63));
      q.element_number    = ELEM_W'($urandom_range(0, 127));
    end else begin
      q.command = CMD_QUERY;
      // Steer toward valid nodes so the edge rule gets exercised.
      if ($urandom_range(0, 9) < 6)
        q.first_atom_right = sb.partner(q.first_atom_left);
      if ($urandom_range(0, 9) < 6)
        q.second_atom_right = sb.partner(q.second_atom_left);
    end
    return q;
  endfunction

  task automatic send_request(input req_t q);
    int gap;
    in_valid <= 1'b1;
    in_data  <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.answers.size() != 0);
  endtask

  initial begin
    req_t plan [$];
    req_t q;
    int   taken;

    plan.insert(plan.size(), mk(CMD_QUERY,   0,  0, 63, 63,   0));
    plan.insert(plan.size(), mk(CMD_SET_L,   0,  0,  0,  0,   6));
    plan.insert(plan.size(), mk(CMD_SET_R,  63,  0, 63, 63,   6));
    plan.insert(plan.size(), mk(CMD_SET_L,  63, 63, 63, 63, 127));
    plan.insert(plan.size(), mk(CMD_SET_R,  63, 63, 63, 63, 127));
    plan.insert(plan.size(), mk(CMD_SET_L,   1, 63, 63, 63,   1));
    plan.insert(plan.size(), mk(CMD_SET_R,   1,  1,  0,  0,   1));
    plan.insert(plan.size(), mk(CMD_SET_R,   0, 63,  0,  0,   6));
    plan.insert(plan.size(), mk(CMD_QUERY,   0, 63, 63, 63,   0));
    plan.insert(plan.size(), mk(CMD_BOND_L,  0,  0, 63,  0,   0));
    plan.insert(plan.size(), mk(CMD_QUERY,   0, 63, 63, 63,   0));
    plan.insert(plan.size(), mk(CMD_BOND_R,  0, 63,  0, 63, 127));
    plan.insert(plan.size(), mk(CMD_QUERY,   0, 63, 63, 63, 127));
    plan.insert(plan.size(), mk(CMD_QUERY,   1,  1,  0, 63,   0));
    // self bond: reported, but the nodes share an atom
    plan.insert(plan.size(), mk(CMD_BOND_L, 63,  0, 63,  0,   0));
    plan.insert(plan.size(), mk(CMD_QUERY,  63, 63, 63, 63,   0));
    plan.insert(plan.size(), mk(CMD_SPARE_6, 63, 63, 63, 63, 127));
    plan.insert(plan.size(), mk(CMD_SPARE_7, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(CMD_CLEAR,   0,  0,  0,  0,   0));
    plan.insert(plan.size(), mk(CMD_QUERY,  63, 63,  0, 63,   0));
    plan.insert(plan.size(), mk(CMD_QUERY,   0, 63, 63, 63,   0));
    // empty a slot again
    plan.insert(plan.size(), mk(CMD_SET_L,   0,  0,  0,  0,   0));
    plan.insert(plan.size(), mk(CMD_QUERY,   0, 63, 63, 63,   0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_request(plan[i]);

    taken = 0;
    while (taken < RANDOM_REQUESTS) begin
      q = random_request();
      if (q.command != CMD_SPARE_6 && q.command != CMD_SPARE_7)
        taken++;
      send_request(q);
      if (taken == RANDOM_REQUESTS / 2 && q.command != CMD_SPARE_6
          && q.command != CMD_SPARE_7)
        drain_results();
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
